### rtl/core/rca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_pkg
// Types, widths and register indexes shared by the rounded corner alpha block.
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAME_BITS  = COORD_BITS + 1;
  localparam int RADIUS_BITS = 8;
  localparam int CHAN_BITS   = 8;

  // register port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = FRAME_BITS;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CORNER_RADIUS = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BG_ALPHA      = 2'd3;

  localparam logic [FRAME_BITS-1:0]  RST_FRAME_WIDTH   = 13'd256;
  localparam logic [FRAME_BITS-1:0]  RST_FRAME_HEIGHT  = 13'd64;
  localparam logic [RADIUS_BITS-1:0] RST_CORNER_RADIUS = 8'd6;
  localparam logic [CHAN_BITS-1:0]   RST_BG_ALPHA      = 8'd242;

  // offsets in half pixels and their squares
  localparam int MAG_BITS = COORD_BITS + 1;
  localparam int SQ_BITS  = 2 * MAG_BITS;
  localparam int SUM_BITS = SQ_BITS + 1;

  // root has 8 fraction bits; only roots below (2r+1)*256 matter
  localparam int FRAC_BITS = 8;
  localparam int ROOT_BITS = RADIUS_BITS + 9;
  localparam int VAL_BITS  = 2 * ROOT_BITS;
  localparam int SEL_BITS  = VAL_BITS - 2 * FRAC_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;

  localparam int COV_BITS = 10;
  localparam logic [COV_BITS-1:0] COV_FULL = 10'd512;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
    logic [CHAN_BITS-1:0]  blue_in;
    logic [CHAN_BITS-1:0]  green_in;
    logic [CHAN_BITS-1:0]  red_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] blue_out;
    logic [CHAN_BITS-1:0] green_out;
    logic [CHAN_BITS-1:0] red_out;
    logic [CHAN_BITS-1:0] alpha_out;
  } pixel_out_t;

  // what rides alongside the root extraction
  typedef struct packed {
    logic                   corner;
    logic                   sat;
    logic [RADIUS_BITS-1:0] radius;
    logic [CHAN_BITS-1:0]   blue;
    logic [CHAN_BITS-1:0]   green;
    logic [CHAN_BITS-1:0]   red;
  } side_t;

  typedef struct packed {
    logic [SEL_BITS-1:0] dist_sq;
    side_t               side;
  } geo_t;

  typedef struct packed {
    logic [ROOT_BITS-1:0] q;
    side_t                side;
  } root_t;

endpackage

### rtl/core/rca_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_geom
// Effective radius, corner detection, half-pixel offsets and squared distance.
// ----------------------------------------------------------------------------
module rca_geom import rca_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  pixel_in_t              in_pix,
  input  logic [FRAME_BITS-1:0]  frame_width,
  input  logic [FRAME_BITS-1:0]  frame_height,
  input  logic [RADIUS_BITS-1:0] corner_radius,
  output logic                   out_valid,
  output geo_t                   out_geo
);

  logic [4:0] valid;

  // stage a: effective radius
  logic [FRAME_BITS-2:0]  w_half;
  logic [FRAME_BITS-2:0]  h_half;
  logic [FRAME_BITS-2:0]  r_ext;
  logic [RADIUS_BITS-1:0] r_w;
  logic [RADIUS_BITS-1:0] r_min;
  pixel_in_t              a_pix;
  logic [RADIUS_BITS-1:0] a_r;

  // stage b: arc centre positions on the far edges
  pixel_in_t              b_pix;
  logic [RADIUS_BITS-1:0] b_r;
  logic [FRAME_BITS-1:0]  b_wr;
  logic [FRAME_BITS-1:0]  b_hr;

  // stage c: corner flags and distances from the centre
  logic [COORD_BITS-1:0]  r_coord;
  logic                   x_left;
  logic                   x_right;
  logic                   y_top;
  logic                   y_bottom;
  logic [CHAN_BITS-1:0]   c_blue;
  logic [CHAN_BITS-1:0]   c_green;
  logic [CHAN_BITS-1:0]   c_red;
  logic [RADIUS_BITS-1:0] c_r;
  logic                   c_corner;
  logic                   c_left;
  logic                   c_top;
  logic [COORD_BITS-1:0]  c_dx;
  logic [COORD_BITS-1:0]  c_dy;

  // stage d: squares
  logic [MAG_BITS-1:0]    dx_mag;
  logic [MAG_BITS-1:0]    dy_mag;
  side_t                  d_side;
  logic [SQ_BITS-1:0]     d_sqx;
  logic [SQ_BITS-1:0]     d_sqy;

  // stage e: sum, with a flag for sums whose root is past any useful radius
  logic [SUM_BITS-1:0]    sum;
  side_t                  e_side;

  assign w_half = frame_width[FRAME_BITS-1:1];
  assign h_half = frame_height[FRAME_BITS-1:1];
  assign r_ext  = {{(FRAME_BITS-1-RADIUS_BITS){1'b0}}, corner_radius};

  always_comb begin
    r_w = corner_radius;
    if (r_ext > w_half) begin
      r_w = w_half[RADIUS_BITS-1:0];
    end
    r_min = r_w;
    if ({{(FRAME_BITS-1-RADIUS_BITS){1'b0}}, r_w} > h_half) begin
      r_min = h_half[RADIUS_BITS-1:0];
    end
  end

  assign r_coord  = {{(COORD_BITS-RADIUS_BITS){1'b0}}, b_r};
  assign x_left   = b_pix.x_pos < r_coord;
  assign x_right  = {1'b0, b_pix.x_pos} >= b_wr;
  assign y_top    = b_pix.y_pos < r_coord;
  assign y_bottom = {1'b0, b_pix.y_pos} >= b_hr;

  assign dx_mag = c_left ? {c_dx, 1'b0} - MAG_BITS'(1) : {c_dx, 1'b0} + MAG_BITS'(1);
  assign dy_mag = c_top  ? {c_dy, 1'b0} - MAG_BITS'(1) : {c_dy, 1'b0} + MAG_BITS'(1);

  assign sum = {1'b0, d_sqx} + {1'b0, d_sqy};

  always_comb begin
    e_side     = d_side;
    e_side.sat = |sum[SUM_BITS-1:SEL_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pix <= in_pix;
      a_r   <= r_min;

      b_pix <= a_pix;
      b_r   <= a_r;
      b_wr  <= frame_width - {{(FRAME_BITS-RADIUS_BITS){1'b0}}, a_r};
      b_hr  <= frame_height - {{(FRAME_BITS-RADIUS_BITS){1'b0}}, a_r};

      c_blue   <= b_pix.blue_in;
      c_green  <= b_pix.green_in;
      c_red    <= b_pix.red_in;
      c_r      <= b_r;
      c_corner <= (b_r != '0) && (x_left || x_right) && (y_top || y_bottom);
      c_left   <= x_left;
      c_top    <= y_top;
      c_dx     <= x_left ? r_coord - b_pix.x_pos : b_pix.x_pos - b_wr[COORD_BITS-1:0];
      c_dy     <= y_top  ? r_coord - b_pix.y_pos : b_pix.y_pos - b_hr[COORD_BITS-1:0];

      d_side.corner <= c_corner;
      d_side.sat    <= 1'b0;
      d_side.radius <= c_r;
      d_side.blue   <= c_blue;
      d_side.green  <= c_green;
      d_side.red    <= c_red;
      d_sqx         <= dx_mag * dx_mag;
      d_sqy         <= dy_mag * dy_mag;

      out_geo.dist_sq <= sum[SEL_BITS-1:0];
      out_geo.side    <= e_side;
    end
  end

  assign out_valid = valid[4];

endmodule

### rtl/core/rca_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_isqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rca_isqrt import rca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  geo_t  in_geo,
  output logic  out_valid,
  output root_t out_root
);

  logic                 st_valid [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] st_root  [0:ROOT_BITS];
  logic [REM_BITS-1:0]  st_rem   [0:ROOT_BITS];
  logic [VAL_BITS-1:0]  st_val   [0:ROOT_BITS];
  side_t                st_side  [0:ROOT_BITS];

  // radicand is the squared distance shifted up by 16
  assign st_valid[0] = in_valid;
  assign st_root[0]  = '0;
  assign st_rem[0]   = '0;
  assign st_val[0]   = {in_geo.dist_sq, {(2*FRAC_BITS){1'b0}}};
  assign st_side[0]  = in_geo.side;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
    logic [REM_BITS+1:0] rem_sh;
    logic [REM_BITS+1:0] trial;
    logic                take;

    assign rem_sh = {st_rem[k], st_val[k][VAL_BITS-1:VAL_BITS-2]};
    assign trial  = {2'b00, st_root[k], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (en) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_root[k+1] <= {st_root[k][ROOT_BITS-2:0], take};
        st_rem[k+1]  <= take ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
        st_val[k+1]  <= {st_val[k][VAL_BITS-3:0], 2'b00};
        st_side[k+1] <= st_side[k];
      end
    end
  end

  assign out_valid     = st_valid[ROOT_BITS];
  assign out_root.q    = st_root[ROOT_BITS];
  assign out_root.side = st_side[ROOT_BITS];

endmodule

### rtl/core/rca_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_shade
// Coverage from the root, alpha scaling and colour premultiply by alpha/255.
// ----------------------------------------------------------------------------
module rca_shade import rca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  root_t                in_root,
  input  logic [CHAN_BITS-1:0] bg_alpha,
  output logic                 out_valid,
  output pixel_out_t           out_pix
);

  logic [3:0] valid;

  // stage 1: coverage
  logic [ROOT_BITS-1:0] target;
  logic [ROOT_BITS-1:0] diff;
  logic [COV_BITS-1:0]  cov;
  logic [COV_BITS-1:0]  s1_cov;
  logic [CHAN_BITS-1:0] s1_blue;
  logic [CHAN_BITS-1:0] s1_green;
  logic [CHAN_BITS-1:0] s1_red;

  // stage 2: alpha
  logic [COV_BITS+CHAN_BITS-1:0] scaled;
  logic [CHAN_BITS-1:0] s2_alpha;
  logic [CHAN_BITS-1:0] s2_blue;
  logic [CHAN_BITS-1:0] s2_green;
  logic [CHAN_BITS-1:0] s2_red;

  // stage 3: products
  logic [CHAN_BITS-1:0]   s3_alpha;
  logic [2*CHAN_BITS-1:0] s3_pb;
  logic [2*CHAN_BITS-1:0] s3_pg;
  logic [2*CHAN_BITS-1:0] s3_pr;

  // stage 4: divide by 255, exact for products of two 8-bit values
  logic [2*CHAN_BITS:0] qb;
  logic [2*CHAN_BITS:0] qg;
  logic [2*CHAN_BITS:0] qr;

  assign target = {in_root.side.radius, 1'b1, {FRAC_BITS{1'b0}}};
  assign diff   = target - in_root.q;

  always_comb begin
    if (!in_root.side.corner) begin
      cov = COV_FULL;
    end else if (in_root.side.sat || in_root.q >= target) begin
      cov = '0;
    end else if (diff > {{(ROOT_BITS-COV_BITS){1'b0}}, COV_FULL}) begin
      cov = COV_FULL;
    end else begin
      cov = diff[COV_BITS-1:0];
    end
  end

  // full coverage gives back bg_alpha exactly, so flat pixels go the same way
  assign scaled = s1_cov * bg_alpha + (COV_BITS+CHAN_BITS)'(256);

  assign qb = {1'b0, s3_pb} + (2*CHAN_BITS+1)'(1) + {{(CHAN_BITS+1){1'b0}}, s3_pb[2*CHAN_BITS-1:CHAN_BITS]};
  assign qg = {1'b0, s3_pg} + (2*CHAN_BITS+1)'(1) + {{(CHAN_BITS+1){1'b0}}, s3_pg[2*CHAN_BITS-1:CHAN_BITS]};
  assign qr = {1'b0, s3_pr} + (2*CHAN_BITS+1)'(1) + {{(CHAN_BITS+1){1'b0}}, s3_pr[2*CHAN_BITS-1:CHAN_BITS]};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cov   <= cov;
      s1_blue  <= in_root.side.blue;
      s1_green <= in_root.side.green;
      s1_red   <= in_root.side.red;

      s2_alpha <= scaled[COV_BITS+CHAN_BITS-2:COV_BITS-1];
      s2_blue  <= s1_blue;
      s2_green <= s1_green;
      s2_red   <= s1_red;

      s3_alpha <= s2_alpha;
      s3_pb    <= s2_blue * s2_alpha;
      s3_pg    <= s2_green * s2_alpha;
      s3_pr    <= s2_red * s2_alpha;

      out_pix.blue_out  <= qb[2*CHAN_BITS-1:CHAN_BITS];
      out_pix.green_out <= qg[2*CHAN_BITS-1:CHAN_BITS];
      out_pix.red_out   <= qr[2*CHAN_BITS-1:CHAN_BITS];
      out_pix.alpha_out <= s3_alpha;
    end
  end

  assign out_valid = valid[3];

endmodule

### rtl/core/rounded_corner_alpha_premultiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_corner_alpha_premultiply
// Rounded-rectangle antialiased alpha mask with colour premultiply.
// ----------------------------------------------------------------------------
// Pixels come in on src (position and opaque colour) under src_valid and
// leave on dst (premultiplied colour and alpha) under dst_valid, in order,
// one result per pixel. A beat moves at a clock edge with valid high and
// stall low.
// Throughput is one pixel per clock while src_stall is low. Most of the
// pipeline is the 17-stage square root, one root bit per stage. The
// pipeline moves as a whole. When the receiver stalls, the output
// register holds its beat and one more beat lands in a skid register; src
// stall is raised only while that skid register is full.
// Registers are to be written through cfg_write, cfg_index and cfg_data
// only while no pixel is in flight; the block itself does not enforce this.
// Reset empties the pipeline, drops both output beats and loads the
// default frame, radius and opacity.
// ----------------------------------------------------------------------------
module rounded_corner_alpha_premultiply import rca_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      src_valid,
  output logic                      src_stall,
  input  pixel_in_t                 src,
  output logic                      dst_valid,
  input  logic                      dst_stall,
  output pixel_out_t                dst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [FRAME_BITS-1:0]  frame_width;
  logic [FRAME_BITS-1:0]  frame_height;
  logic [RADIUS_BITS-1:0] corner_radius;
  logic [CHAN_BITS-1:0]   bg_alpha;

  logic       en;
  logic       geo_valid;
  geo_t       geo;
  logic       root_valid;
  root_t      root;
  logic       pipe_valid;
  pixel_out_t pipe_pix;

  logic       skid_full;
  pixel_out_t skid;
  logic       dst_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      corner_radius <= RST_CORNER_RADIUS;
      bg_alpha      <= RST_BG_ALPHA;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data;
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        CFG_CORNER_RADIUS: corner_radius <= cfg_data[RADIUS_BITS-1:0];
        CFG_BG_ALPHA:      bg_alpha      <= cfg_data[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !skid_full;
  assign src_stall = skid_full;

  rca_geom u_geom (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (src_valid && !skid_full),
    .in_pix        (src),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .corner_radius (corner_radius),
    .out_valid     (geo_valid),
    .out_geo       (geo)
  );

  rca_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (geo_valid),
    .in_geo    (geo),
    .out_valid (root_valid),
    .out_root  (root)
  );

  rca_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in_root   (root),
    .bg_alpha  (bg_alpha),
    .out_valid (pipe_valid),
    .out_pix   (pipe_pix)
  );

  assign dst_take = dst_valid && !dst_stall;

  // output register plus one skid beat
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (dst_take) begin
        skid_full <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (dst_valid && dst_stall) begin
        skid_full <= 1'b1;
      end else begin
        dst_valid <= 1'b1;
      end
    end else if (dst_take) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (dst_take) begin
        dst <= skid;
      end
    end else if (pipe_valid) begin
      if (dst_valid && dst_stall) begin
        skid <= pipe_pix;
      end else begin
        dst <= pipe_pix;
      end
    end
  end

endmodule

### rtl/core/rca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rca_checker
// Port-level checks of the output beat and skid behaviour.
// ----------------------------------------------------------------------------
module rca_checker import rca_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       src_stall,
  input logic       dst_valid,
  input logic       dst_stall,
  input pixel_out_t dst
);

  // a stalled output beat stays put
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst))
    else $error("dst beat changed while stalled");

  // src is held back only while an output beat is waiting
  a_stall_needs_dst: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> dst_valid)
    else $error("src stalled with no output beat pending");

  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(src_stall) |-> $past(dst_valid && dst_stall))
    else $error("src stall raised without a stalled output beat");

  a_stall_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(src_stall) |-> $past(dst_valid && !dst_stall))
    else $error("src stall dropped without an output beat leaving");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !dst_valid && !src_stall)
    else $error("reset left a beat or a stall behind");

endmodule

bind rounded_corner_alpha_premultiply rca_checker u_rca_checker (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst       (dst)
);

### sim/rounded_corner_alpha_premultiply_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_corner_alpha_premultiply_tb
// Self-checking bench for the rounded corner alpha and premultiply block.
// ----------------------------------------------------------------------------
// Pixels go in on the src channel and every accepted beat is run through a
// bit-exact predictor of the corner coverage, the opacity scale and the
// colour premultiply. Results on dst are checked field by field, in order.
// The frame, radius and opacity registers are reprogrammed between bursts
// once the pipe has drained. Both sides idle at random, the receiver holds
// off for a long stretch once so the input backs up.
// ----------------------------------------------------------------------------
module rounded_corner_alpha_premultiply_tb;
  import rca_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_HOLD       = 150;
  localparam int RAND_SETUPS     = 18;
  localparam int ITEMS_PER_SETUP = 90;
  localparam int SETTLE_CYCLES   = 40;
  localparam int MAX_PRINTED     = 50;

  class pixel_scoreboard;
    logic [FRAME_BITS-1:0]  frame_w;
    logic [FRAME_BITS-1:0]  frame_h;
    logic [RADIUS_BITS-1:0] radius_req;
    logic [CHAN_BITS-1:0]   opacity;
    pixel_out_t             expected_q[$];
    int                     mismatches;
    int                     results_checked;
    int                     pixels_noted;

    function new();
      frame_w         = RST_FRAME_WIDTH;
      frame_h         = RST_FRAME_HEIGHT;
      radius_req      = RST_CORNER_RADIUS;
      opacity         = RST_BG_ALPHA;
      mismatches      = 0;
      results_checked = 0;
      pixels_noted    = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH:   frame_w = data;
        CFG_FRAME_HEIGHT:  frame_h = data;
        CFG_CORNER_RADIUS: radius_req = data[RADIUS_BITS-1:0];
        CFG_BG_ALPHA:      opacity = data[CHAN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned step_bit;
      res = 0;
      step_bit = 64'd1 << 62;
      while (step_bit > v) step_bit >>= 2;
      while (step_bit != 0) begin
        if (v >= res + step_bit) begin
          v -= res + step_bit;
          res = (res >> 1) + step_bit;
        end else begin
          res >>= 1;
        end
        step_bit >>= 2;
      end
      return res;
    endfunction

    function logic [CHAN_BITS-1:0] coverage_alpha(longint x, longint y);
      longint w, h, r, cx, cy, dx2, dy2, cov, q;
      w = longint'(frame_w);
      h = longint'(frame_h);
      r = longint'(radius_req);
      if (r > w / 2) r = w / 2;
      if (r > h / 2) r = h / 2;
      if (r <= 0) return opacity;
      if (x < r && y < r) begin
        cx = r; cy = r;
      end else if (x >= w - r && y < r) begin
        cx = w - r; cy = r;
      end else if (x < r && y >= h - r) begin
        cx = r; cy = h - r;
      end else if (x >= w - r && y >= h - r) begin
        cx = w - r; cy = h - r;
      end else begin
        return opacity;
      end
      // offsets in half pixels from the arc centre
      dx2 = 2 * x + 1 - 2 * cx;
      dy2 = 2 * y + 1 - 2 * cy;
      q = longint'(root_floor(longint'(dx2 * dx2 + dy2 * dy2) << 16));
      cov = (2 * r + 1) * 256 - q;
      if (cov < 0) cov = 0;
      if (cov > 512) cov = 512;
      return CHAN_BITS'((cov * longint'(opacity) + 256) >>> 9);
    endfunction

    function void note_pixel(pixel_in_t p);
      pixel_out_t       want;
      logic [CHAN_BITS-1:0] a;
      a = coverage_alpha(longint'(p.x_pos), longint'(p.y_pos));
      want.blue_out  = CHAN_BITS'((int'(p.blue_in) * int'(a)) / 255);
      want.green_out = CHAN_BITS'((int'(p.green_in) * int'(a)) / 255);
      want.red_out   = CHAN_BITS'((int'(p.red_in) * int'(a)) / 255);
      want.alpha_out = a;
      expected_q = {expected_q, want};
      pixels_noted++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      // keep the log readable on a badly broken build
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(pixel_out_t got);
      pixel_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with no pixel waiting", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.blue_out !== want.blue_out)
        report($sformatf("beat %0d blue_out %0d, want %0d",
                         results_checked, got.blue_out, want.blue_out));
      if (got.green_out !== want.green_out)
        report($sformatf("beat %0d green_out %0d, want %0d",
                         results_checked, got.green_out, want.green_out));
      if (got.red_out !== want.red_out)
        report($sformatf("beat %0d red_out %0d, want %0d",
                         results_checked, got.red_out, want.red_out));
      if (got.alpha_out !== want.alpha_out)
        report($sformatf("beat %0d alpha_out %0d, want %0d",
                         results_checked, got.alpha_out, want.alpha_out));
      results_checked++;
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      src_valid = 1'b0;
  logic                      src_stall;
  pixel_in_t                 src = '0;
  logic                      dst_valid;
  logic                      dst_stall = 1'b0;
  pixel_out_t                dst;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  pixel_scoreboard sb = new();

  int  src_idle_pct = 0;
  int  dst_stall_pct = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  int  setups_applied = 1;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;

  rounded_corner_alpha_premultiply uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst       (dst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results still owed", cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check each beat, then decide the next stall
  always @(posedge clk) begin
    if (rst) begin
      dst_stall <= 1'b0;
    end else begin
      if (dst_valid && !dst_stall) sb.check_result(dst);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        dst_stall <= 1'b1;
      end else begin
        dst_stall <= ($urandom_range(99) < dst_stall_pct);
      end
    end
  end

  task automatic send_pixel(input int x, input int y, input int b, input int g, input int r);
    pixel_in_t p;
    p.x_pos    = COORD_BITS'(x);
    p.y_pos    = COORD_BITS'(y);
    p.blue_in  = CHAN_BITS'(b);
    p.green_in = CHAN_BITS'(g);
    p.red_in   = CHAN_BITS'(r);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src       <= p;
    do @(posedge clk); while (src_stall);
    sb.note_pixel(p);
  endtask

  task automatic drain_results();
    src_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_setup(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h,
                             input logic [CFG_DATA_BITS-1:0] rad,
                             input logic [CFG_DATA_BITS-1:0] opa);
    logic [CFG_INDEX_BITS-1:0] idx_list[4];
    logic [CFG_DATA_BITS-1:0]  val_list[4];
    idx_list = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_CORNER_RADIUS, CFG_BG_ALPHA};
    val_list = '{w, h, rad, opa};
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      @(posedge clk);
      sb.write_reg(idx_list[i], val_list[i]);
    end
    cfg_write <= 1'b0;
    setups_applied++;
  endtask

  function automatic int pick_frame_size();
    case ($urandom_range(3))
      0:       return $urandom_range(1, 40);
      1:       return $urandom_range(41, 600);
      2:       return $urandom_range(1, 4096);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // biased towards the arc bands at both ends of an axis
  function automatic int pick_coord(int size, int r);
    int c;
    case ($urandom_range(9))
      0, 1, 2, 3: c = $urandom_range(0, r + 2);
      4, 5, 6:    c = size - 1 - $urandom_range(0, r + 2);
      7, 8:       c = $urandom_range(0, size + 2);
      default:    c = $urandom_range(0, 4095);
    endcase
    if (c < 0 || c > 4095) c = $urandom_range(0, 4095);
    return c;
  endfunction

  initial begin
    int fw, fh, rad_data, opa_data, rr;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset frame: corners, just outside the arc, middle, off-frame, bit patterns
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(255, 0, 0, 0, 0);
    send_pixel(0, 63, 255, 0, 128);
    send_pixel(255, 63, 1, 254, 255);
    send_pixel(5, 5, 200, 100, 50);
    send_pixel(6, 6, 255, 255, 255);
    send_pixel(128, 32, 77, 88, 99);
    send_pixel(4095, 4095, 255, 255, 255);
    send_pixel(2730, 1365, 170, 85, 170);
    send_pixel(1365, 2730, 85, 170, 85);

    // zero width gives no rounding
    apply_setup(0, 64, 6, 242);
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(3, 3, 255, 128, 0);

    // widest frame, largest radius, opaque
    apply_setup(8191, 8191, 255, 255);
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(4095, 4095, 255, 255, 255);
    send_pixel(127, 127, 255, 255, 255);
    send_pixel(255, 255, 255, 255, 255);

    // smallest frame with any rounding
    apply_setup(2, 2, 1, 128);
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(1, 1, 255, 255, 255);

    // radius with junk above its width, fully transparent
    apply_setup(40, 40, 13'h1F14, 0);
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(20, 20, 255, 255, 255);
    send_pixel(39, 0, 255, 255, 255);

    // rounding off
    apply_setup(100, 100, 0, 200);
    send_pixel(0, 0, 255, 255, 255);

    for (int phase = 0; phase < RAND_SETUPS; phase++) begin
      if (phase == 0) begin
        src_idle_pct  <= 8;
        dst_stall_pct <= 68;
      end else if (phase == RAND_SETUPS / 3) begin
        src_idle_pct  <= 68;
        dst_stall_pct <= 8;
      end else if (phase == 2 * RAND_SETUPS / 3) begin
        src_idle_pct  <= 0;
        dst_stall_pct <= 0;
      end
      fw = pick_frame_size();
      fh = pick_frame_size();
      rad_data = $urandom_range(1) ? $urandom_range(0, 24) : $urandom_range(0, 8191);
      opa_data = ($urandom_range(3) == 0) ? 255 : $urandom_range(0, 8191);
      apply_setup(CFG_DATA_BITS'(fw), CFG_DATA_BITS'(fh), CFG_DATA_BITS'(rad_data),
                  CFG_DATA_BITS'(opa_data));
      rr = rad_data & 255;
      if (rr > fw / 2) rr = fw / 2;
      if (rr > fh / 2) rr = fh / 2;
      // long receiver hold so the pipe fills and src backs up
      if (phase == 1) hold_req <= ~hold_req;
      for (int n = 0; n < ITEMS_PER_SETUP; n++)
        send_pixel(pick_coord(fw, rr), pick_coord(fh, rr), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("%0d pixels over %0d register setups, %0d beats checked, %0d mismatches",
             sb.pixels_noted, setups_applied, sb.results_checked, sb.mismatches);
    $display("zero and widest frames, masked radius, off-frame pixels and a long dst hold-off");
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rca_pkg.sv
rtl/core/rca_geom.sv
rtl/core/rca_isqrt.sv
rtl/core/rca_shade.sv
rtl/core/rounded_corner_alpha_premultiply.sv
rtl/core/rca_checker.sv
sim/rounded_corner_alpha_premultiply_tb.sv
